// ----- rtl/core/msc_pkg.sv -----
// Shared constants, types and arithmetic helpers for the magnetometer sphere calibrator.
`timescale 1ns / 1ps

package msc_pkg;

    // Fixed-point format of the field, center and radius values.
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_W     = 32;
    localparam int RES_W       = 48;
    localparam int GAIN_W      = 32;
    localparam int LIMIT_W     = 47;
    localparam int SQ_W        = 2 * FIELD_W;
    localparam int FG_W        = RES_W + GAIN_W;
    localparam int ACC_W       = FG_W + FIELD_W;
    localparam int STEP_SHIFT  = 38 + FRAC_BITS;
    localparam int Q_W         = ACC_W - STEP_SHIFT;
    localparam int STEP_CAP_W  = 41;
    localparam int DELTA_W     = STEP_CAP_W + 1;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = LIMIT_W;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 1'b1;

    // Item kinds; the unused code behaves like a plain correction.
    localparam logic [1:0] KIND_CORRECT   = 2'd0;
    localparam logic [1:0] KIND_CALIBRATE = 2'd1;
    localparam logic [1:0] KIND_RESET     = 2'd2;

    // Partial-product chunk selects for the step multiplication.
    localparam logic [1:0] STEP_LO  = 2'd0;
    localparam logic [1:0] STEP_MID = 2'd1;
    localparam logic [1:0] STEP_HI  = 2'd2;

    // Reset values of the calibration state and limit register; step and residual caps.
    localparam logic signed [FIELD_W-1:0] RADIUS_INIT = FIELD_W'(10 << FRAC_BITS);
    localparam logic [LIMIT_W-1:0]        LIMIT_INIT  = {LIMIT_W{1'b1}};
    localparam logic [Q_W-1:0]            STEP_CAP    = Q_W'(1) << (STEP_CAP_W - 1);
    localparam logic signed [SQ_W:0]      RES_MAX     = (SQ_W + 1)'((65'sd1 <<< 47) - 65'sd1);

    // Controls sent from the sequencer to each lane.
    typedef struct packed {
        logic       sq_en;
        logic       step_en;
        logic [1:0] step_idx;
    } lane_ctrl_t;

    // Controls sent from the sequencer to the merge stage.
    typedef struct packed {
        logic sum_en;
        logic resid_en;
        logic fg_en;
        logic fg_hi;
    } merge_ctrl_t;

    // Saturate a wide signed value to the 32-bit field range.
    function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = {1'b0, {(FIELD_W-1){1'b1}}};
        end
        else if (v < -64'sd2147483648)
        begin
            r = {1'b1, {(FIELD_W-1){1'b0}}};
        end
        else
        begin
            r = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    // Scale a raw sample to microtesla and remove the hard-iron center.
    function automatic logic signed [FIELD_W-1:0] correct_axis(
        input logic signed [15:0]         raw,
        input logic signed [FIELD_W-1:0]  center
    );
        logic signed [63:0]        scaled;
        logic signed [FIELD_W-1:0] scaled_sat;
        logic signed [63:0]        diff;
        scaled     = 64'(raw) <<< (FRAC_BITS - 4);
        scaled_sat = sat32(scaled);
        diff       = 64'(scaled_sat) - 64'(center);
        return sat32(diff);
    endfunction

endpackage

// ----- rtl/core/msc_if.sv -----
// Stream interfaces for raw samples in and corrected results out.
`timescale 1ns / 1ps

interface msc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] x_low_byte;
    logic [7:0] x_high_byte;
    logic [7:0] y_low_byte;
    logic [7:0] y_high_byte;
    logic [7:0] z_low_byte;
    logic [7:0] z_high_byte;

    modport source (
        output valid, kind, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
               z_low_byte, z_high_byte,
        output ready
    );
endinterface

interface msc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
    logic signed [47:0] residual;
    logic               updated;
    logic               was_reset;

    modport source (
        output valid, field_x, field_y, field_z, residual, updated, was_reset,
        input  ready
    );
    modport sink (
        input  valid, field_x, field_y, field_z, residual, updated, was_reset,
        output ready
    );
endinterface

// ----- rtl/core/msc_lane.sv -----
// One calibration lane: squares its operand and forms its LMS update step.
`timescale 1ns / 1ps

module msc_lane (
    input  logic                               clk,
    input  msc_pkg::lane_ctrl_t                ctrl,
    input  logic signed [msc_pkg::FIELD_W-1:0] operand,
    input  logic signed [msc_pkg::FIELD_W-1:0] old_value,
    input  logic [msc_pkg::FG_W-1:0]           fg,
    input  logic                               f_neg,
    output logic [msc_pkg::SQ_W-1:0]           square,
    output logic signed [msc_pkg::FIELD_W-1:0] new_value
);
    import msc_pkg::*;

    logic [FIELD_W-1:0]          op_mag;
    logic [FIELD_W-1:0]          chunk;
    logic [FIELD_W-1:0]          mul_a;
    logic [SQ_W-1:0]             prod;
    logic [SQ_W-1:0]             sq_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [Q_W-1:0]              q;
    logic [STEP_CAP_W-1:0]       q_cap;
    logic signed [DELTA_W-1:0]   delta;
    logic                        neg;

    // Magnitude of the operand; the most negative value maps to 2^31.
    assign op_mag = operand[FIELD_W-1] ? (~operand + 1'b1) : operand;

    // Select the 32-bit slice of the gain-residual product for this step.
    always_comb
    begin
        unique case (ctrl.step_idx)
            STEP_LO:  chunk = fg[31:0];
            STEP_MID: chunk = fg[63:32];
            STEP_HI:  chunk = FIELD_W'(fg[FG_W-1:64]);
            default:  chunk = '0;
        endcase
    end

    // The lane multiplier serves the square first and then the step products.
    assign mul_a = ctrl.sq_en ? op_mag : chunk;
    assign prod  = mul_a * op_mag;

    // Square and step accumulator.
    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            sq_reg <= prod;
        end
        if (ctrl.step_en)
        begin
            unique case (ctrl.step_idx)
                STEP_LO:  acc_reg <= ACC_W'(prod);
                STEP_MID: acc_reg <= acc_reg + {16'b0, prod, 32'b0};
                STEP_HI:  acc_reg <= acc_reg + {prod[ACC_W-65:0], 64'b0};
                default:  acc_reg <= acc_reg;
            endcase
        end
    end

    assign square = sq_reg;

    // Truncate the step, cap its magnitude and apply it with saturation.
    assign q     = acc_reg[ACC_W-1:STEP_SHIFT];
    assign q_cap = (q > STEP_CAP) ? STEP_CAP[STEP_CAP_W-1:0] : q[STEP_CAP_W-1:0];
    assign neg   = f_neg ^ operand[FIELD_W-1];
    assign delta = neg ? -$signed({1'b0, q_cap}) : $signed({1'b0, q_cap});

    assign new_value = sat32(64'(old_value) + 64'(delta));

endmodule

// ----- rtl/core/msc_merge.sv -----
// Merge stage: sums the lane squares into the residual and forms gain times residual.
`timescale 1ns / 1ps

module msc_merge (
    input  logic                               clk,
    input  msc_pkg::merge_ctrl_t               ctrl,
    input  logic [msc_pkg::SQ_W-1:0]           sq_x,
    input  logic [msc_pkg::SQ_W-1:0]           sq_y,
    input  logic [msc_pkg::SQ_W-1:0]           sq_z,
    input  logic [msc_pkg::SQ_W-1:0]           sq_r,
    input  logic [msc_pkg::GAIN_W-1:0]         gain,
    input  logic [msc_pkg::LIMIT_W-1:0]        limit,
    output logic signed [msc_pkg::RES_W-1:0]   residual,
    output logic                               over,
    output logic [msc_pkg::FG_W-1:0]           fg
);
    import msc_pkg::*;

    logic [SQ_W-1:0]          sumsq_reg;
    logic [SQ_W-1:0]          r2_reg;
    logic signed [SQ_W:0]     diff;
    logic signed [SQ_W:0]     shifted;
    logic signed [RES_W-1:0]  f_next;
    logic signed [RES_W-1:0]  f_reg;
    logic [RES_W-1:0]         fa;
    logic [GAIN_W-1:0]        mul_a;
    logic [SQ_W-1:0]          prod;
    logic [FG_W-1:0]          fg_reg;

    // Residual: floor of (|m|^2 - r^2) / 2^FRAC_BITS, capped at the top.
    assign diff    = $signed({1'b0, sumsq_reg}) - $signed({1'b0, r2_reg});
    assign shifted = diff >>> FRAC_BITS;
    assign f_next  = (shifted > RES_MAX) ? RES_MAX[RES_W-1:0] : shifted[RES_W-1:0];

    // Residual magnitude split into a low word and a high half-word.
    assign fa    = f_reg[RES_W-1] ? (~f_reg + 1'b1) : f_reg;
    assign mul_a = ctrl.fg_hi ? GAIN_W'(fa[RES_W-1:32]) : fa[31:0];
    assign prod  = mul_a * gain;

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sumsq_reg <= sq_x + sq_y + sq_z;
            r2_reg    <= sq_r;
        end
        if (ctrl.resid_en)
        begin
            f_reg <= f_next;
        end
        if (ctrl.fg_en)
        begin
            if (ctrl.fg_hi)
            begin
                fg_reg <= fg_reg + {prod[FG_W-33:0], 32'b0};
            end
            else
            begin
                fg_reg <= FG_W'(prod);
            end
        end
    end

    // A positive residual above the limit triggers a calibration reset.
    assign over     = !f_reg[RES_W-1] && (f_reg[LIMIT_W-1:0] > limit);
    assign residual = f_reg;
    assign fg       = fg_reg;

endmodule

// ----- rtl/core/magnetometer_sphere_calibrator_top.sv -----
// Top level of the magnetometer hard-iron calibrator with LMS sphere fit.
//
// Channels: "sample" carries one item (kind and six raw data bytes) per
// transfer; "result" carries the corrected X/Y/Z field, the residual and the
// updated / was_reset flags. Both use valid/ready. The configuration port
// writes gain (index 0) and reset_limit (index 1); the user must write them
// only while the block is idle, as the block itself does not enforce it.
//
// Steps per item, from the input transfer to the result being loaded into
// the output register: a reset item goes straight to the load; a correct-only
// item passes square, sum and residual; a calibrate item goes on through two
// gain partial products on the merge multiplier and three step partial
// products on the four lane multipliers, then applies the step, but stops
// after the first gain product if its residual trips the reset limit. One
// item is in work at a time; the input opens again the cycle after the load,
// and a new item is taken while the previous result still waits.
//
// Reset clears the center to 0, the radius to 10.0, gain to 0 and the limit
// to its maximum. When the receiver stalls, the finished result holds in the
// output register and the next item waits in its final cycle until the
// register frees up.
`timescale 1ns / 1ps

module magnetometer_sphere_calibrator_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    msc_in_if.sink                                sample,
    msc_out_if.source                             result,
    input  logic                                  cfg_write,
    input  logic [msc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import msc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_RESID,
        ST_FG_LO,
        ST_FG_HI,
        ST_STEP0,
        ST_STEP1,
        ST_STEP2,
        ST_APPLY,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [1:0]                 kind_reg;
    logic signed [FIELD_W-1:0]  m_x_reg;
    logic signed [FIELD_W-1:0]  m_y_reg;
    logic signed [FIELD_W-1:0]  m_z_reg;
    logic signed [FIELD_W-1:0]  center_x_reg;
    logic signed [FIELD_W-1:0]  center_y_reg;
    logic signed [FIELD_W-1:0]  center_z_reg;
    logic signed [FIELD_W-1:0]  radius_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [LIMIT_W-1:0]         limit_reg;
    logic                       upd_reg;
    logic                       rst_flag_reg;
    logic                       out_valid_reg;
    logic signed [FIELD_W-1:0]  out_x_reg;
    logic signed [FIELD_W-1:0]  out_y_reg;
    logic signed [FIELD_W-1:0]  out_z_reg;
    logic signed [RES_W-1:0]    out_res_reg;
    logic                       out_upd_reg;
    logic                       out_rst_reg;

    logic                       accept;
    logic                       out_free;
    logic signed [FIELD_W-1:0]  corr_x;
    logic signed [FIELD_W-1:0]  corr_y;
    logic signed [FIELD_W-1:0]  corr_z;
    lane_ctrl_t                 lane_ctrl;
    merge_ctrl_t                merge_ctrl;
    logic [SQ_W-1:0]            sq_x;
    logic [SQ_W-1:0]            sq_y;
    logic [SQ_W-1:0]            sq_z;
    logic [SQ_W-1:0]            sq_r;
    logic signed [FIELD_W-1:0]  new_x;
    logic signed [FIELD_W-1:0]  new_y;
    logic signed [FIELD_W-1:0]  new_z;
    logic signed [FIELD_W-1:0]  new_r;
    logic signed [RES_W-1:0]    residual;
    logic                       over;
    logic [FG_W-1:0]            fg;

    // Handshakes.
    assign sample.ready = (state_reg == ST_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign out_free     = !out_valid_reg || result.ready;

    // Unpack the raw bytes, scale and subtract the current center.
    assign corr_x = correct_axis(16'($signed({sample.x_high_byte, sample.x_low_byte[7:3]})),
                                 center_x_reg);
    assign corr_y = correct_axis(16'($signed({sample.y_high_byte, sample.y_low_byte[7:3]})),
                                 center_y_reg);
    assign corr_z = correct_axis(16'($signed({sample.z_high_byte, sample.z_low_byte[7:1]})),
                                 center_z_reg);

    // Lane and merge controls decoded from the sequencer state.
    always_comb
    begin
        lane_ctrl.sq_en    = (state_reg == ST_SQUARE);
        lane_ctrl.step_en  = (state_reg == ST_STEP0) || (state_reg == ST_STEP1) ||
                             (state_reg == ST_STEP2);
        lane_ctrl.step_idx = (state_reg == ST_STEP1) ? STEP_MID :
                             (state_reg == ST_STEP2) ? STEP_HI : STEP_LO;
        merge_ctrl.sum_en   = (state_reg == ST_SUM);
        merge_ctrl.resid_en = (state_reg == ST_RESID);
        merge_ctrl.fg_en    = (state_reg == ST_FG_LO) || (state_reg == ST_FG_HI);
        merge_ctrl.fg_hi    = (state_reg == ST_FG_HI);
    end

    // Four lanes: the three field axes and the radius.
    msc_lane u_lane_x (
        .clk(clk), .ctrl(lane_ctrl), .operand(m_x_reg), .old_value(center_x_reg),
        .fg(fg), .f_neg(residual[RES_W-1]), .square(sq_x), .new_value(new_x)
    );
    msc_lane u_lane_y (
        .clk(clk), .ctrl(lane_ctrl), .operand(m_y_reg), .old_value(center_y_reg),
        .fg(fg), .f_neg(residual[RES_W-1]), .square(sq_y), .new_value(new_y)
    );
    msc_lane u_lane_z (
        .clk(clk), .ctrl(lane_ctrl), .operand(m_z_reg), .old_value(center_z_reg),
        .fg(fg), .f_neg(residual[RES_W-1]), .square(sq_z), .new_value(new_z)
    );
    msc_lane u_lane_r (
        .clk(clk), .ctrl(lane_ctrl), .operand(radius_reg), .old_value(radius_reg),
        .fg(fg), .f_neg(residual[RES_W-1]), .square(sq_r), .new_value(new_r)
    );

    msc_merge u_merge (
        .clk(clk), .ctrl(merge_ctrl), .sq_x(sq_x), .sq_y(sq_y), .sq_z(sq_z),
        .sq_r(sq_r), .gain(gain_reg), .limit(limit_reg), .residual(residual),
        .over(over), .fg(fg)
    );

    // Sequencer, calibration state, configuration and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_CORRECT;
            m_x_reg       <= '0;
            m_y_reg       <= '0;
            m_z_reg       <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= RADIUS_INIT;
            gain_reg      <= '0;
            limit_reg     <= LIMIT_INIT;
            upd_reg       <= 1'b0;
            rst_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_z_reg     <= '0;
            out_res_reg   <= '0;
            out_upd_reg   <= 1'b0;
            out_rst_reg   <= 1'b0;
        end
        else
        begin
            // Configuration writes.
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_GAIN:  gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:   gain_reg  <= gain_reg;
                endcase
            end

            // The output register empties on a result transfer, unless the
            // sequencer loads the next result in the same cycle.
            if (result.valid && result.ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        m_x_reg      <= corr_x;
                        m_y_reg      <= corr_y;
                        m_z_reg      <= corr_z;
                        kind_reg     <= sample.kind;
                        upd_reg      <= 1'b0;
                        rst_flag_reg <= (sample.kind == KIND_RESET);
                        if (sample.kind == KIND_RESET)
                        begin
                            center_x_reg <= '0;
                            center_y_reg <= '0;
                            center_z_reg <= '0;
                            radius_reg   <= RADIUS_INIT;
                            state_reg    <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: state_reg <= ST_SUM;
                ST_SUM:    state_reg <= ST_RESID;
                ST_RESID:
                begin
                    state_reg <= (kind_reg == KIND_CALIBRATE) ? ST_FG_LO : ST_DONE;
                end
                ST_FG_LO:
                begin
                    // Residual above the limit: restart the calibration.
                    if (over)
                    begin
                        center_x_reg <= '0;
                        center_y_reg <= '0;
                        center_z_reg <= '0;
                        radius_reg   <= RADIUS_INIT;
                        rst_flag_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_FG_HI;
                    end
                end
                ST_FG_HI:  state_reg <= ST_STEP0;
                ST_STEP0:  state_reg <= ST_STEP1;
                ST_STEP1:  state_reg <= ST_STEP2;
                ST_STEP2:  state_reg <= ST_APPLY;
                ST_APPLY:
                begin
                    center_x_reg <= new_x;
                    center_y_reg <= new_y;
                    center_z_reg <= new_z;
                    radius_reg   <= new_r;
                    upd_reg      <= 1'b1;
                    state_reg    <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= m_x_reg;
                        out_y_reg     <= m_y_reg;
                        out_z_reg     <= m_z_reg;
                        out_res_reg   <= (kind_reg == KIND_RESET) ? '0 : residual;
                        out_upd_reg   <= upd_reg;
                        out_rst_reg   <= rst_flag_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.field_x   = out_x_reg;
    assign result.field_y   = out_y_reg;
    assign result.field_z   = out_z_reg;
    assign result.residual  = out_res_reg;
    assign result.updated   = out_upd_reg;
    assign result.was_reset = out_rst_reg;

endmodule

// ----- rtl/core/msc_checker.sv -----
// Port-level checks for the calibrator top level, bound to it.
`timescale 1ns / 1ps

module msc_checker (
    input logic       clk,
    input logic       rst_n,
    msc_in_if.sink    sample,
    msc_out_if.source result
);

    // A stalled result stays offered.
    property p_out_valid_holds;
        @(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> result.valid;
    endproperty
    a_out_valid_holds: assert property (p_out_valid_holds)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    property p_out_payload_holds;
        @(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=>
            ($stable(result.field_x) && $stable(result.field_y) &&
             $stable(result.field_z) && $stable(result.residual) &&
             $stable(result.updated) && $stable(result.was_reset));
    endproperty
    a_out_payload_holds: assert property (p_out_payload_holds)
        else $error("result payload changed while stalled");

    // An item is never both adapted and reset.
    property p_flags_exclusive;
        @(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.updated && result.was_reset);
    endproperty
    a_flags_exclusive: assert property (p_flags_exclusive)
        else $error("updated and was_reset both set");

    // Only one item is in work: the input closes right after a transfer.
    property p_one_in_work;
        @(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready;
    endproperty
    a_one_in_work: assert property (p_one_in_work)
        else $error("sample taken while an item is in work");

endmodule

bind magnetometer_sphere_calibrator_top msc_checker u_msc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .sample(sample),
    .result(result)
);
